FILE: hdl/amem_pkg.sv
// package for the atomic memory block: command codes, fsm states, payload structs
// and helper functions. no dependencies.
package amem_pkg;

  localparam int unsigned AMEM_MEM_BYTES = 65536;
  localparam int unsigned AMEM_PADDR_W   = 4;
  localparam int unsigned AMEM_DIV_STEPS = 32;

  localparam logic [6:0]  AMEM_PAGE_PENALTY = 7'd5;
  localparam logic [7:0]  AMEM_BYTE_MASK    = 8'hFF;

  localparam logic [5:0]  AMEM_CAS_RST   = 6'd11;
  localparam logic [4:0]  AMEM_BURST_RST = 5'd8;
  localparam logic [16:0] AMEM_PAGE_RST  = 17'd4096;

  // register indexes
  localparam logic [1:0] REG_CAS   = 2'd0;
  localparam logic [1:0] REG_BURST = 2'd1;
  localparam logic [1:0] REG_PAGE  = 2'd2;

  // command codes
  localparam logic [3:0] CMD_READ  = 4'd0;
  localparam logic [3:0] CMD_WRITE = 4'd1;
  localparam logic [3:0] CMD_ADD   = 4'd2;
  localparam logic [3:0] CMD_SWAP  = 4'd3;
  localparam logic [3:0] CMD_CAS   = 4'd4;
  localparam logic [3:0] CMD_SUB   = 4'd5;
  localparam logic [3:0] CMD_AND   = 4'd6;
  localparam logic [3:0] CMD_OR    = 4'd7;
  localparam logic [3:0] CMD_XOR   = 4'd8;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_FINISH
  } amem_state_t;

  typedef struct packed {
    logic [3:0]  command;
    logic [31:0] address;
    logic [31:0] operand;
    logic [31:0] compare_value;
  } amem_req_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        in_range;
    logic [6:0]  access_latency;
    logic [31:0] reads_total;
    logic [31:0] writes_total;
    logic [31:0] latency_total;
  } amem_rsp_t;

  // ceil(4 / burst length), zero treated as one
  function automatic logic [2:0] amem_burst_cycles(input logic [4:0] bl);
    logic [2:0] res;
    if (bl <= 5'd1) begin
      res = 3'd4;
    end else if (bl <= 5'd3) begin
      res = 3'd2;
    end else begin
      res = 3'd1;
    end
    return res;
  endfunction

endpackage

FILE: hdl/amem_if.sv
// valid/ready channel interfaces for the request and response sides.
// depends on amem_pkg.
interface amem_req_if import amem_pkg::*;;
  logic      valid;
  logic      ready;
  amem_req_t payload;
  modport source  (output valid, output payload, input ready);
  modport sink    (input valid, input payload, output ready);
  modport monitor (input valid, input payload, input ready);
endinterface

interface amem_rsp_if import amem_pkg::*;;
  logic      valid;
  logic      ready;
  amem_rsp_t payload;
  modport source  (output valid, output payload, input ready);
  modport sink    (input valid, input payload, output ready);
  modport monitor (input valid, input payload, input ready);
endinterface

FILE: hdl/atomic_memory_with_latency_model.sv
// Byte-addressed memory with atomic read-modify-write and an access latency model.
// Each transaction is accepted, then the address is divided bit-serially by the page
// size, then the result is written back and loaded into the result register.
// A result waiting in the output register stalls only the final write-back step.
// After reset a clearing pass zeroes the four byte banks before the first transaction
// is accepted. Depends on amem_pkg, amem_if.
module atomic_memory_with_latency_model import amem_pkg::*; #(
  parameter int unsigned MEM_BYTES = AMEM_MEM_BYTES
) (
  input  logic                    clk,
  input  logic                    rst_n,
  amem_req_if.sink                in_if,
  amem_rsp_if.source              out_if,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [AMEM_PADDR_W-1:0] paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  localparam int unsigned ROWS = (MEM_BYTES + 3) / 4;
  localparam int unsigned RW   = (ROWS > 1) ? $clog2(ROWS) : 1;

  amem_state_t state_r, state_nxt;

  logic [5:0]  cas_r;
  logic [4:0]  burst_r;
  logic [16:0] page_r;

  logic [3:0]  cmd_r;
  logic [31:0] addr_r, opnd_r, cmpv_r;
  logic        ok_r;

  logic [16:0] rem_r;
  logic [31:0] quo_r;
  logic [4:0]  div_cnt_r;
  logic [RW-1:0] clr_cnt_r;

  logic [31:0] prev_page_r, reads_r, writes_r, lat_sum_r;
  logic        out_valid_r;
  amem_rsp_t   out_r;

  logic [7:0]    bank_rd_r [4];
  logic          bank_we [4];
  logic [RW-1:0] bank_row [4];
  logic [RW-1:0] bank_waddr [4];
  logic [7:0]    bank_wdata [4];

  logic in_ready, accept, fin_fire, clr_last, div_last;

  // config port
  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cas_r   <= AMEM_CAS_RST;
      burst_r <= AMEM_BURST_RST;
      page_r  <= AMEM_PAGE_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_CAS:   cas_r   <= pwdata[5:0];
        REG_BURST: burst_r <= pwdata[4:0];
        REG_PAGE:  page_r  <= pwdata[16:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_CAS:   prdata = {26'd0, cas_r};
      REG_BURST: prdata = {27'd0, burst_r};
      REG_PAGE:  prdata = {15'd0, page_r};
      default:   prdata = 32'd0;
    endcase
  end

  // fsm
  assign clr_last = (clr_cnt_r == RW'(ROWS - 1));
  assign div_last = (div_cnt_r == 5'(AMEM_DIV_STEPS - 1));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR:  if (clr_last) state_nxt = ST_IDLE;
      ST_IDLE:   if (in_if.valid) state_nxt = ST_DIV;
      ST_DIV:    if (div_last) state_nxt = ST_FINISH;
      ST_FINISH: if (!out_valid_r || out_if.ready) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    fin_fire = 1'b0;
    case (state_r)
      ST_IDLE:   in_ready = 1'b1;
      ST_FINISH: fin_fire = !out_valid_r || out_if.ready;
      default:   ;
    endcase
  end

  assign in_if.ready = in_ready;
  assign accept      = in_ready & in_if.valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) clr_cnt_r <= clr_cnt_r + RW'(1);
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r  <= in_if.payload.command;
      addr_r <= in_if.payload.address;
      opnd_r <= in_if.payload.operand;
      cmpv_r <= in_if.payload.compare_value;
      ok_r   <= ({1'b0, in_if.payload.address} + 33'd4) <= 33'(MEM_BYTES);
    end
  end

  // restoring divider: address / page size, one quotient bit a cycle
  logic [16:0] ps_eff;
  logic [17:0] div_t;
  logic        div_ge;
  logic [17:0] div_sub;
  assign ps_eff  = (page_r == 17'd0) ? 17'd1 : page_r;
  assign div_t   = {rem_r, quo_r[31]};
  assign div_ge  = div_t >= {1'b0, ps_eff};
  assign div_sub = div_t - {1'b0, ps_eff};

  always_ff @(posedge clk) begin
    if (accept) begin
      rem_r     <= '0;
      quo_r     <= in_if.payload.address;
      div_cnt_r <= '0;
    end else if (state_r == ST_DIV) begin
      rem_r     <= div_ge ? div_sub[16:0] : div_t[16:0];
      quo_r     <= {quo_r[30:0], div_ge};
      div_cnt_r <= div_cnt_r + 5'd1;
    end
  end

  // byte banks: bank b holds bytes whose address is b mod 4
  logic [31:0] old_word, new_word;
  always_comb begin
    for (int b = 0; b < 4; b++) begin
      logic [1:0]  k;
      logic [31:0] s;
      k = 2'(b) - addr_r[1:0];
      s = addr_r + {30'd0, k};
      bank_row[b] = s[RW+1:2];
    end
    for (int k = 0; k < 4; k++) begin
      old_word[8*k +: 8] = bank_rd_r[2'(addr_r[1:0] + 2'(k))];
    end
  end

  genvar g;
  for (g = 0; g < 4; g++) begin : g_bank
    logic [7:0] mem [ROWS];
    always_ff @(posedge clk) begin
      if (bank_we[g]) mem[bank_waddr[g]] <= bank_wdata[g];
      bank_rd_r[g] <= mem[bank_row[g]];
    end
  end

  // read-modify-write and latency
  logic is_atomic, wr_en, counted, rd_inc, wr_inc;
  logic [6:0]  lat;
  logic [31:0] data;
  always_comb begin
    is_atomic = (cmd_r >= CMD_ADD) && (cmd_r <= CMD_XOR);
    new_word  = opnd_r;
    wr_en     = 1'b0;
    case (cmd_r)
      CMD_WRITE: wr_en = ok_r;
      CMD_ADD:   begin new_word = old_word + opnd_r; wr_en = ok_r; end
      CMD_SWAP:  wr_en = ok_r;
      CMD_CAS:   wr_en = ok_r && (old_word == cmpv_r);
      CMD_SUB:   begin new_word = old_word - opnd_r; wr_en = ok_r; end
      CMD_AND:   begin new_word = old_word & opnd_r; wr_en = ok_r; end
      CMD_OR:    begin new_word = old_word | opnd_r; wr_en = ok_r; end
      CMD_XOR:   begin new_word = old_word ^ opnd_r; wr_en = ok_r; end
      default:   wr_en = 1'b0;
    endcase
    counted = (cmd_r == CMD_READ) || (cmd_r == CMD_WRITE) || (is_atomic && ok_r);
    rd_inc  = (cmd_r == CMD_READ) || (is_atomic && ok_r);
    wr_inc  = (cmd_r == CMD_WRITE) || (is_atomic && wr_en);
    lat     = 7'(cas_r) + 7'(amem_burst_cycles(burst_r))
            + ((quo_r != prev_page_r) ? AMEM_PAGE_PENALTY : 7'd0);
    if (!counted) lat = 7'd0;
    data = (((cmd_r == CMD_READ) || is_atomic) && ok_r) ? old_word : 32'd0;
  end

  always_comb begin
    for (int b = 0; b < 4; b++) begin
      logic [1:0] k;
      k = 2'(b) - addr_r[1:0];
      if (state_r == ST_CLEAR) begin
        bank_we[b]    = 1'b1;
        bank_waddr[b] = clr_cnt_r;
        bank_wdata[b] = 8'd0;
      end else begin
        bank_we[b]    = fin_fire && wr_en;
        bank_waddr[b] = bank_row[b];
        bank_wdata[b] = 8'(new_word >> (8 * k)) & AMEM_BYTE_MASK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_page_r <= '0;
      reads_r     <= '0;
      writes_r    <= '0;
      lat_sum_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (fin_fire) begin
        if (counted) prev_page_r <= quo_r;
        reads_r     <= reads_r + {31'd0, rd_inc};
        writes_r    <= writes_r + {31'd0, wr_inc};
        lat_sum_r   <= lat_sum_r + {25'd0, lat};
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fin_fire) begin
      out_r.read_data      <= data;
      out_r.in_range       <= ok_r;
      out_r.access_latency <= lat;
      out_r.reads_total    <= reads_r + {31'd0, rd_inc};
      out_r.writes_total   <= writes_r + {31'd0, wr_inc};
      out_r.latency_total  <= lat_sum_r + {25'd0, lat};
    end
  end

  assign out_if.valid   = out_valid_r;
  assign out_if.payload = out_r;

endmodule

FILE: tb/amem_scoreboard.sv
// checker for the atomic memory: watches both channels and the register port,
// predicts each response and compares it field by field. depends on amem_pkg, amem_if.
`timescale 1ns / 100ps
module amem_scoreboard import amem_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  amem_req_if.monitor        req_mon,
  amem_rsp_if.monitor        rsp_mon,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [AMEM_PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output int                 fail_count,
  output int                 pending_count
);
  logic [7:0]  mem_model [AMEM_MEM_BYTES];
  logic [31:0] prev_page, reads_cnt, writes_cnt, lat_sum;
  logic [5:0]  cas_lat;
  logic [4:0]  burst_len;
  logic [16:0] page_sz;
  amem_rsp_t   expected_rsp_q [$];

  assign pending_count = expected_rsp_q.size();

  function automatic logic [31:0] load_word(logic [31:0] a);
    return {mem_model[a+3], mem_model[a+2], mem_model[a+1], mem_model[a]};
  endfunction

  task automatic store_word(logic [31:0] a, logic [31:0] v);
    mem_model[a]   = v[7:0];
    mem_model[a+1] = v[15:8];
    mem_model[a+2] = v[23:16];
    mem_model[a+3] = v[31:24];
  endtask

  function automatic logic [31:0] charge_access(logic [31:0] a);
    logic [31:0] bl, ps, lat, pg;
    bl  = (burst_len == 0) ? 32'd1 : 32'(burst_len);
    ps  = (page_sz == 0) ? 32'd1 : 32'(page_sz);
    lat = 32'(cas_lat) + (32'd4 + bl - 32'd1) / bl;
    pg  = a / ps;
    if (pg != prev_page) begin
      lat += 32'(AMEM_PAGE_PENALTY);
      prev_page = pg;
    end
    return lat;
  endfunction

  task automatic predict_access(amem_req_t r);
    amem_rsp_t   e;
    logic        ok, wr;
    logic [31:0] old, nv, lat, data;
    ok   = ({32'd0, r.address} + 64'd4) <= 64'(AMEM_MEM_BYTES);
    data = '0;
    lat  = '0;
    if (r.command == CMD_READ) begin
      lat = charge_access(r.address);
      reads_cnt++;
      if (ok) data = load_word(r.address);
    end else if (r.command == CMD_WRITE) begin
      lat = charge_access(r.address);
      writes_cnt++;
      if (ok) store_word(r.address, r.operand);
    end else if (r.command <= CMD_XOR && ok) begin
      old = load_word(r.address);
      wr  = 1'b1;
      case (r.command)
        CMD_ADD:  nv = old + r.operand;
        CMD_SWAP: nv = r.operand;
        CMD_CAS: begin
          wr = (old == r.compare_value);
          nv = r.operand;
        end
        CMD_SUB:  nv = old - r.operand;
        CMD_AND:  nv = old & r.operand;
        CMD_OR:   nv = old | r.operand;
        default:  nv = old ^ r.operand;
      endcase
      if (wr) store_word(r.address, nv);
      lat = charge_access(r.address);
      reads_cnt++;
      if (wr) writes_cnt++;
      data = old;
    end
    lat_sum += lat;
    e.read_data      = data;
    e.in_range       = ok;
    e.access_latency = lat[6:0];
    e.reads_total    = reads_cnt;
    e.writes_total   = writes_cnt;
    e.latency_total  = lat_sum;
    expected_rsp_q.push_back(e);
  endtask

  task automatic compare_rsp(amem_rsp_t a);
    amem_rsp_t e;
    if (expected_rsp_q.size() == 0) begin
      $error("response with nothing expected: %p", a);
      fail_count++;
      return;
    end
    e = expected_rsp_q.pop_front();
    if (a.read_data != e.read_data) begin
      $error("read_data exp %h got %h", e.read_data, a.read_data); fail_count++;
    end
    if (a.in_range != e.in_range) begin
      $error("in_range exp %0d got %0d", e.in_range, a.in_range); fail_count++;
    end
    if (a.access_latency != e.access_latency) begin
      $error("access_latency exp %0d got %0d", e.access_latency, a.access_latency);
      fail_count++;
    end
    if (a.reads_total != e.reads_total) begin
      $error("reads_total exp %0d got %0d", e.reads_total, a.reads_total); fail_count++;
    end
    if (a.writes_total != e.writes_total) begin
      $error("writes_total exp %0d got %0d", e.writes_total, a.writes_total);
      fail_count++;
    end
    if (a.latency_total != e.latency_total) begin
      $error("latency_total exp %0d got %0d", e.latency_total, a.latency_total);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (mem_model[i]) mem_model[i] = '0;
      prev_page  = '0;
      reads_cnt  = '0;
      writes_cnt = '0;
      lat_sum    = '0;
      cas_lat    = AMEM_CAS_RST;
      burst_len  = AMEM_BURST_RST;
      page_sz    = AMEM_PAGE_RST;
      fail_count = 0;
      expected_rsp_q.delete();
    end else begin
      if (psel && penable && pwrite) begin
        case (paddr[AMEM_PADDR_W-1:2])
          REG_CAS:   cas_lat   = pwdata[5:0];
          REG_BURST: burst_len = pwdata[4:0];
          REG_PAGE:  page_sz   = pwdata[16:0];
          default: ;
        endcase
      end
      // response checked first: a request accepted this edge cannot answer now
      if (rsp_mon.valid && rsp_mon.ready) compare_rsp(rsp_mon.payload);
      if (req_mon.valid && req_mon.ready) predict_access(req_mon.payload);
    end
  end
endmodule

FILE: tb/atomic_memory_with_latency_model_tb.sv
// testbench top for the atomic memory: makes requests, register writes and
// response stalls; the verdict comes from amem_scoreboard. depends on amem_pkg, amem_if.
`timescale 1ns / 100ps
module atomic_memory_with_latency_model_tb;
  import amem_pkg::*;

  logic clk, rst_n;
  logic psel, penable, pwrite, pready;
  logic [AMEM_PADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;
  int fail_count, pending_count;
  logic [31:0] hot_addr [8];

  amem_req_if req_ch();
  amem_rsp_if rsp_ch();

  atomic_memory_with_latency_model dut (
    .clk(clk), .rst_n(rst_n), .in_if(req_ch.sink), .out_if(rsp_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  amem_scoreboard checker_i (
    .clk(clk), .rst_n(rst_n), .req_mon(req_ch.monitor), .rsp_mon(rsp_ch.monitor),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // timeout covering the clearing pass plus ~2000 transactions at worst-case gaps
  initial begin
    #22000000;
    $display("Some tests failed");
    $finish;
  end

  function automatic int unsigned gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 80);
    return $urandom_range(0, 3);
  endfunction

  // response-side stalls, with quiet stretches
  initial begin
    int unsigned n;
    rsp_ch.ready = 1'b0;
    @(posedge clk);
    forever begin
      n = gap_len();
      if ($urandom_range(0, 3) == 0) n = 0;
      if (n > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk);
    end
  end

  task automatic reg_write(logic [1:0] idx, logic [31:0] v);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= AMEM_PADDR_W'({idx, 2'b00}); pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // valid drops only before a gap, so back-to-back transactions keep it high
  task automatic send_req(logic [3:0] c, logic [31:0] a, logic [31:0] op,
                          logic [31:0] cv, bit gaps);
    int unsigned n;
    n = gaps ? gap_len() : 0;
    if (gaps && $urandom_range(0, 2) == 0) n = 0;
    if (n > 0) begin
      req_ch.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.payload <= '{command: c, address: a, operand: op, compare_value: cv};
    do @(posedge clk); while (!req_ch.ready);
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_addr();
    case ($urandom_range(0, 9))
      0:       return $urandom();
      1:       return AMEM_MEM_BYTES - $urandom_range(0, 8);
      2:       return 32'hFFFF_FFFF - $urandom_range(0, 4);
      3, 4, 5: return hot_addr[$urandom_range(0, 7)] + $urandom_range(0, 3);
      default: return $urandom_range(0, AMEM_MEM_BYTES - 4);
    endcase
  endfunction

  task automatic random_phase(int cnt);
    logic [31:0] a, op;
    logic [3:0] c;
    for (int i = 0; i < cnt; i++) begin
      a  = rand_addr();
      c  = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(9, 15))
                                         : 4'($urandom_range(0, 8));
      op = ($urandom_range(0, 4) == 0) ? 32'hFFFF_FFFF : $urandom();
      send_req(c, a, op, ($urandom_range(0, 1) == 0) ? op : $urandom(), 1'b1);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.payload = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    foreach (hot_addr[i]) hot_addr[i] = $urandom_range(0, AMEM_MEM_BYTES - 8);
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, every command, range edges, cas both ways
    send_req(CMD_READ,  32'd0, 32'd0, 32'd0, 1'b0);
    send_req(CMD_WRITE, 32'd0, 32'hFFFF_FFFF, 32'd0, 1'b0);
    send_req(CMD_WRITE, AMEM_MEM_BYTES - 4, 32'hA5C3_0F81, 32'd0, 1'b0);
    send_req(CMD_READ,  AMEM_MEM_BYTES - 4, 32'd0, 32'd0, 1'b0);
    send_req(CMD_READ,  AMEM_MEM_BYTES - 3, 32'd0, 32'd0, 1'b0);
    send_req(CMD_WRITE, 32'hFFFF_FFFE, 32'h1234_5678, 32'd0, 1'b0);
    send_req(CMD_ADD,   32'd0, 32'd1, 32'd0, 1'b0);
    send_req(CMD_SWAP,  32'd2, 32'h5A5A_5A5A, 32'd0, 1'b0);
    send_req(CMD_CAS,   32'd2, 32'hDEAD_BEEF, 32'h5A5A_5A5A, 1'b0);
    send_req(CMD_CAS,   32'd2, 32'h0, 32'hFFFF_FFFF, 1'b0);
    send_req(CMD_SUB,   32'd4, 32'd7, 32'd0, 1'b0);
    send_req(CMD_AND,   32'd4, 32'h0F0F_F0F0, 32'd0, 1'b0);
    send_req(CMD_OR,    32'd5, 32'h8000_0001, 32'd0, 1'b0);
    send_req(CMD_XOR,   32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    send_req(CMD_ADD,   AMEM_MEM_BYTES - 2, 32'd1, 32'd0, 1'b0);
    send_req(CMD_CAS,   32'hFFFF_FFFF, 32'd1, 32'd0, 1'b0);
    send_req(4'd15,     32'd0, 32'd1, 32'd1, 1'b0);
    send_req(4'd9,      32'hFFFF_FFFF, 32'd1, 32'd1, 1'b0);
    send_req(CMD_READ,  32'd0, 32'd0, 32'd0, 1'b0);
    drain();

    random_phase(450);
    drain();
    // zero burst and page, minimum cas
    reg_write(REG_CAS, 32'd0);
    reg_write(REG_BURST, 32'd0);
    reg_write(REG_PAGE, 32'd0);
    random_phase(350);
    drain();
    reg_write(REG_CAS, 32'hFFFF_FFFF);
    reg_write(REG_BURST, 32'd16);
    reg_write(REG_PAGE, 32'h1_0000);
    random_phase(350);
    drain();
    reg_write(REG_CAS, 32'd63);
    reg_write(REG_BURST, 32'd1);
    reg_write(REG_PAGE, 32'd1);
    random_phase(350);
    drain();
    reg_write(REG_CAS, $urandom_range(0, 63));
    reg_write(REG_BURST, $urandom_range(2, 31));
    reg_write(REG_PAGE, $urandom_range(2, 131071));
    random_phase(430);
    drain();

    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
